// ===== src/sva_pkg.sv =====
package sva_pkg;

  localparam int OP_W    = 3;
  localparam int NOTE_W  = 7;
  localparam int VEL_W   = 7;
  localparam int SLEN_W  = 20;
  localparam int KIND_W  = 2;
  localparam int VOICE_W = 4;
  localparam int POS_W   = 20;
  localparam int GAIN_W  = 7;

  typedef enum logic [OP_W-1:0] {
    OP_TICK      = 3'd0,
    OP_NOTE_ON   = 3'd1,
    OP_LOAD      = 3'd2,
    OP_CLEAR     = 3'd3,
    OP_STOP_ALL  = 3'd4
  } op_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_REPORT   = 2'd0,
    KIND_ACCEPTED = 2'd1,
    KIND_IGNORED  = 2'd2,
    KIND_DONE     = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    OUT_NONE,
    OUT_REPORT,
    OUT_ACCEPT,
    OUT_IGNORE,
    OUT_DONE
  } out_sel_t;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [NOTE_W-1:0] note;
    logic [VEL_W-1:0]  velocity;
    logic [SLEN_W-1:0] sample_length;
  } in_item_t;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [VOICE_W-1:0] voice;
    logic               playing;
    logic [NOTE_W-1:0]  voice_note;
    logic [POS_W-1:0]   position;
    logic [GAIN_W-1:0]  gain;
    logic               last;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     load_item;
    logic     idx_inc;
    logic     idx_clr;
    logic     latch_voice;
    logic     tick_commit;
    logic     set_slot;
    logic     note_commit;
    logic     apply;
    out_sel_t out_sel;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            note_ok;
    logic            idx_last;
    logic            report;
    logic            active_idx;
    logic            match;
    logic            out_free;
  } status_t;

endpackage

// ===== src/sva_ram.sv =====
module sva_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/sva_ctrl.sv =====
module sva_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_ready,
  input  sva_pkg::status_t status,
  output sva_pkg::cmd_t    cmd
);

  import sva_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE     = 10'b0000000001,
    S_DISPATCH = 10'b0000000010,
    S_T_LATCH  = 10'b0000000100,
    S_T_EVAL   = 10'b0000001000,
    S_T_RD     = 10'b0000010000,
    S_N_FREE   = 10'b0000100000,
    S_N_RD     = 10'b0001000000,
    S_N_CMP    = 10'b0010000000,
    S_N_COMMIT = 10'b0100000000,
    S_RESP     = 10'b1000000000
  } state_t;

  state_t state, state_next;

  assign item_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.out_sel = OUT_NONE;
    unique case (state)
      S_IDLE: begin
        if (item_valid) begin
          cmd.load_item = 1'b1;
          state_next    = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        priority case (status.op)
          OP_TICK:    state_next = S_T_LATCH;
          OP_NOTE_ON: state_next = status.note_ok ? S_N_FREE : S_RESP;
          OP_LOAD, OP_CLEAR, OP_STOP_ALL: begin
            cmd.apply  = 1'b1;
            state_next = S_RESP;
          end
          default:    state_next = S_IDLE;
        endcase
      end
      S_T_LATCH: begin
        cmd.latch_voice = 1'b1;
        state_next      = S_T_EVAL;
      end
      S_T_EVAL: begin
        if (!status.report || status.out_free) begin
          cmd.tick_commit = 1'b1;
          cmd.idx_inc     = 1'b1;
          if (status.report) begin
            cmd.out_sel = OUT_REPORT;
          end
          state_next = status.idx_last ? S_IDLE : S_T_RD;
        end
      end
      S_T_RD: begin
        state_next = S_T_LATCH;
      end
      S_N_FREE: begin
        if (!status.active_idx) begin
          cmd.set_slot = 1'b1;
          state_next   = S_N_COMMIT;
        end else if (status.idx_last) begin
          cmd.idx_clr = 1'b1;
          state_next  = S_N_RD;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      S_N_RD: begin
        state_next = S_N_CMP;
      end
      S_N_CMP: begin
        // With no voice on the same note the slot stays at voice 0.
        if (status.match) begin
          cmd.set_slot = 1'b1;
          state_next   = S_N_COMMIT;
        end else if (status.idx_last) begin
          state_next = S_N_COMMIT;
        end else begin
          cmd.idx_inc = 1'b1;
          state_next  = S_N_RD;
        end
      end
      S_N_COMMIT: begin
        if (status.out_free) begin
          cmd.note_commit = 1'b1;
          cmd.out_sel     = OUT_ACCEPT;
          state_next      = S_IDLE;
        end
      end
      S_RESP: begin
        if (status.out_free) begin
          cmd.out_sel = (status.op == OP_NOTE_ON) ? OUT_IGNORE : OUT_DONE;
          state_next  = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ===== src/sva_datapath.sv =====
module sva_datapath #(
  parameter int VOICES      = 16,
  parameter int NOTES       = 128,
  parameter int LENGTH_BITS = 20
) (
  input  logic                clk,
  input  logic                rst,
  input  sva_pkg::in_item_t   item,
  input  sva_pkg::cmd_t       cmd,
  output sva_pkg::status_t    status,
  output logic                result_valid,
  input  logic                result_ready,
  output sva_pkg::out_item_t  result
);

  import sva_pkg::*;

  localparam int IW   = VOICES > 1 ? $clog2(VOICES) : 1;
  localparam int NB   = NOTES > 1 ? $clog2(NOTES) : 1;
  localparam int LB   = LENGTH_BITS;
  localparam int VW   = NOTE_W + LB + GAIN_W;
  localparam int NREP = VOICES < 16 ? VOICES : 16;

  in_item_t         cur_item;
  logic [IW-1:0]    idx;
  logic [IW-1:0]    slot;
  logic [VOICES-1:0] active;
  logic [VOICES-1:0] written;
  logic [NOTES-1:0] loaded;

  logic             vrd_ok;
  logic [VW-1:0]    v_rdata;
  logic [VW-1:0]    vdat;
  logic [NOTE_W-1:0] vdat_note;
  logic             v_we;
  logic [IW-1:0]    v_waddr;
  logic [VW-1:0]    v_wdata;
  logic [LB-1:0]    len_rdata;

  logic [NOTE_W-1:0] cur_note;
  logic [LB-1:0]     cur_pos;
  logic [GAIN_W-1:0] cur_gain;

  logic          cur_loaded;
  logic          play;
  logic [LB-1:0] pos_w;
  logic          act_next;
  logic          report;
  logic          rep_last;
  logic          out_free;
  out_item_t     res_next;

  function automatic logic note_in_range(input logic [NOTE_W-1:0] n);
    return {1'b0, n} < 8'(NOTES);
  endfunction

  // Entries never written read as zero, which is their reset value.
  assign vdat      = vrd_ok ? v_rdata : '0;
  assign vdat_note = vdat[VW-1 -: NOTE_W];

  assign v_we    = cmd.tick_commit | cmd.note_commit;
  assign v_waddr = cmd.note_commit ? slot : idx;
  assign v_wdata = cmd.note_commit ?
                   {cur_item.note, {LB{1'b0}}, cur_item.velocity} :
                   {cur_note, pos_w, cur_gain};

  sva_ram #(.WIDTH(VW), .DEPTH(VOICES)) u_voice_ram (
    .clk   (clk),
    .we    (v_we),
    .waddr (v_waddr),
    .wdata (v_wdata),
    .raddr (idx),
    .rdata (v_rdata)
  );

  sva_ram #(.WIDTH(LB), .DEPTH(NOTES)) u_len_ram (
    .clk   (clk),
    .we    (cmd.apply && cur_item.op == OP_LOAD && note_in_range(cur_item.note)),
    .waddr (cur_item.note[NB-1:0]),
    .wdata (LB'(cur_item.sample_length)),
    .raddr (vdat_note[NB-1:0]),
    .rdata (len_rdata)
  );

  // Tick evaluation of the latched voice against its sample length.
  assign cur_loaded = note_in_range(cur_note) && loaded[cur_note[NB-1:0]];
  assign play       = active[idx] && cur_loaded && (cur_pos < len_rdata);
  assign pos_w      = play ? cur_pos + LB'(1) : cur_pos;
  assign act_next   = play && (pos_w < len_rdata);
  assign report     = 7'(idx) < 7'(NREP);
  assign rep_last   = 7'(idx) == 7'(NREP - 1);
  assign out_free   = !result_valid || result_ready;

  always_comb begin
    status.op         = cur_item.op;
    status.note_ok    = note_in_range(cur_item.note) && (cur_item.velocity != '0) &&
                        loaded[cur_item.note[NB-1:0]];
    status.idx_last   = idx == IW'(VOICES - 1);
    status.report     = report;
    status.active_idx = active[idx];
    status.match      = vdat_note == cur_item.note;
    status.out_free   = out_free;
  end

  always_comb begin
    res_next = '0;
    res_next.last = 1'b1;
    unique case (cmd.out_sel)
      OUT_REPORT: begin
        res_next.kind       = KIND_REPORT;
        res_next.voice      = VOICE_W'(idx);
        res_next.playing    = play;
        res_next.voice_note = cur_note;
        res_next.position   = POS_W'(cur_pos);
        res_next.gain       = cur_gain;
        res_next.last       = rep_last;
      end
      OUT_ACCEPT: begin
        res_next.kind       = KIND_ACCEPTED;
        res_next.voice      = VOICE_W'(slot);
        res_next.voice_note = cur_item.note;
        res_next.gain       = cur_item.velocity;
      end
      OUT_IGNORE: res_next.kind = KIND_IGNORED;
      OUT_DONE:   res_next.kind = KIND_DONE;
      default:    res_next.kind = KIND_REPORT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active       <= '0;
      written      <= '0;
      loaded       <= '0;
      result_valid <= 1'b0;
      idx          <= '0;
      slot         <= '0;
      vrd_ok       <= 1'b0;
    end else begin
      vrd_ok <= written[idx];

      if (cmd.load_item || cmd.idx_clr) begin
        idx <= '0;
      end else if (cmd.idx_inc) begin
        idx <= idx + IW'(1);
      end

      if (cmd.load_item) begin
        slot <= '0;
      end else if (cmd.set_slot) begin
        slot <= idx;
      end

      if (cmd.tick_commit) begin
        active[idx]  <= act_next;
        written[idx] <= 1'b1;
      end
      if (cmd.note_commit) begin
        active[slot]  <= 1'b1;
        written[slot] <= 1'b1;
      end

      if (cmd.apply) begin
        priority case (cur_item.op)
          OP_LOAD: begin
            if (note_in_range(cur_item.note)) begin
              loaded[cur_item.note[NB-1:0]] <= 1'b1;
            end
          end
          OP_CLEAR: begin
            if (note_in_range(cur_item.note)) begin
              loaded[cur_item.note[NB-1:0]] <= 1'b0;
            end
          end
          OP_STOP_ALL: active <= '0;
          default: ;
        endcase
      end

      if (cmd.out_sel != OUT_NONE) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      cur_item <= item;
    end
    if (cmd.latch_voice) begin
      cur_note <= vdat_note;
      cur_pos  <= vdat[GAIN_W +: LB];
      cur_gain <= vdat[GAIN_W-1:0];
    end
    if (cmd.out_sel != OUT_NONE) begin
      result <= res_next;
    end
  end

endmodule

// ===== src/sample_voice_allocator.sv =====
// Tick: a dispatch step, then for each voice slot a read, a latch with length lookup,
// and an update with report; a reporting update waits while the last result is not taken.
// Note-on: a free-voice scan over the voices; if none is free, a note-match scan
// through the voice table port, with a read and a compare step per voice.
// Load, clear and stop are applied at dispatch. One item is in work at a time.
// Reset clears voice activity, loaded flags and voice entry valid bits at once.
module sample_voice_allocator #(
  parameter int VOICES      = 16,
  parameter int NOTES       = 128,
  parameter int LENGTH_BITS = 20
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_ready,
  input  sva_pkg::in_item_t  item,
  output logic               result_valid,
  input  logic               result_ready,
  output sva_pkg::out_item_t result
);

  import sva_pkg::*;

  cmd_t    cmd;
  status_t status;

  sva_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .status     (status),
    .cmd        (cmd)
  );

  sva_datapath #(
    .VOICES      (VOICES),
    .NOTES       (NOTES),
    .LENGTH_BITS (LENGTH_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .item         (item),
    .cmd          (cmd),
    .status       (status),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule
